[rtl/tvn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_pkg
// shared widths, register codes and item types of the value noise texel unit
// ----------------------------------------------------------------------------
package tvn_pkg;

    // tile and octave setup
    localparam int TILE_SIZE   = 256;
    localparam int TILE_W      = $clog2(TILE_SIZE);
    localparam int MAX_OCTAVES = 4;
    localparam int OCT_CNT_W   = $clog2(MAX_OCTAVES + 1);

    // field widths
    localparam int COORD_W = 8;
    localparam int CH_W    = 8;
    localparam int BASE_W  = 15;
    localparam int VAR_W   = 16;
    localparam int PER_W   = 9;
    localparam int AMT_W   = 15;

    // fixed point
    localparam int FRAC_W     = 24;
    localparam int COLOR_FRAC = 14;
    localparam int IDX_W      = TILE_W;
    localparam int SUM_W      = FRAC_W + MAX_OCTAVES;

    // lattice hash multipliers
    localparam logic [31:0] MIX_X = 32'd374761393;
    localparam logic [31:0] MIX_Y = 32'd668265263;
    localparam logic [31:0] MIX_F = 32'd1274126177;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [BASE_W-1:0] RST_BASE_RED   = 15'd6881;
    localparam logic [BASE_W-1:0] RST_BASE_GREEN = 15'd7373;
    localparam logic [BASE_W-1:0] RST_BASE_BLUE  = 15'd6226;
    localparam logic [VAR_W-1:0]  RST_VAR        = 16'd16384;
    localparam logic [PER_W-1:0]  RST_PERIOD     = 9'd16;
    localparam logic [AMT_W-1:0]  RST_AMOUNT     = 15'd1638;

    typedef enum logic [2:0] {
        REG_BASE_RED   = 3'd0,
        REG_BASE_GREEN = 3'd1,
        REG_BASE_BLUE  = 3'd2,
        REG_VAR_RED    = 3'd3,
        REG_VAR_GREEN  = 3'd4,
        REG_VAR_BLUE   = 3'd5,
        REG_PERIOD     = 3'd6,
        REG_AMOUNT     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [BASE_W-1:0] base_red;
        logic [BASE_W-1:0] base_green;
        logic [BASE_W-1:0] base_blue;
        logic [VAR_W-1:0]  var_red;
        logic [VAR_W-1:0]  var_green;
        logic [VAR_W-1:0]  var_blue;
        logic [PER_W-1:0]  noise_period;
        logic [AMT_W-1:0]  mottle_amount;
    } cfg_t;

    // lattice corners and in-cell fractions of one octave
    typedef struct packed {
        logic [IDX_W-1:0]  x0;
        logic [IDX_W-1:0]  x1;
        logic [IDX_W-1:0]  y0;
        logic [IDX_W-1:0]  y1;
        logic [TILE_W-1:0] fx;
        logic [TILE_W-1:0] fy;
    } oct_coord_t;

    typedef struct packed {
        oct_coord_t [MAX_OCTAVES-1:0] oct;
        logic [OCT_CNT_W-1:0]         oct_cnt;
    } item_t;

endpackage
`default_nettype wire

[rtl/tileable_value_noise_texel_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tileable_value_noise_texel_unit
// seamless mottled texel from a pixel position using fractal value noise
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------
//  input     in_valid / in_stall     x_coord, y_coord
//  output    out_valid / out_stall   red_out, green_out, blue_out
//  config    apb psel/penable        paddr, pwdata, prdata (pready tied)
//
//  one item per cycle sustained while the output is not stalled; the front
//  register loads at the accepting edge, then the item passes a queue slot,
//  ten noise and colour stages and the output register, where out_valid rises
//  reset clears the valid bits and loads the register defaults, no sweep
//  an output stall freezes the back pipeline; the two-entry queue and the
//  front register absorb items until in_stall rises
//
module tileable_value_noise_texel_unit
    import tvn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // pixel in
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic               in_valid,
    output logic               in_stall,
    // texel out
    output logic [CH_W-1:0]    red_out,
    output logic [CH_W-1:0]    green_out,
    output logic [CH_W-1:0]    blue_out,
    output logic               out_valid,
    input  logic               out_stall
);

    cfg_t  cfg;
    item_t front_item;
    item_t queue_item;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;

    // register file
    tvn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: octave count and lattice cells per octave
    tvn_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .noise_period (cfg.noise_period),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (front_item)
    );

    // decoupling queue
    tvn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (queue_item)
    );

    // back: hashing, blending, octave mix and colour
    tvn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (queue_item),
        .q_pop     (q_pop),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule
`default_nettype wire

[rtl/tvn_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_cfg
// apb register file holding colour, variation, period and amount settings
// ----------------------------------------------------------------------------
module tvn_cfg
    import tvn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_BASE_RED:   cfg_next.base_red      = pwdata[BASE_W-1:0];
                REG_BASE_GREEN: cfg_next.base_green    = pwdata[BASE_W-1:0];
                REG_BASE_BLUE:  cfg_next.base_blue     = pwdata[BASE_W-1:0];
                REG_VAR_RED:    cfg_next.var_red       = pwdata[VAR_W-1:0];
                REG_VAR_GREEN:  cfg_next.var_green     = pwdata[VAR_W-1:0];
                REG_VAR_BLUE:   cfg_next.var_blue      = pwdata[VAR_W-1:0];
                REG_PERIOD:     cfg_next.noise_period  = pwdata[PER_W-1:0];
                REG_AMOUNT:     cfg_next.mottle_amount = pwdata[AMT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BASE_RED:   prdata = DATA_W'(cfg_reg.base_red);
            REG_BASE_GREEN: prdata = DATA_W'(cfg_reg.base_green);
            REG_BASE_BLUE:  prdata = DATA_W'(cfg_reg.base_blue);
            REG_VAR_RED:    prdata = DATA_W'(cfg_reg.var_red);
            REG_VAR_GREEN:  prdata = DATA_W'(cfg_reg.var_green);
            REG_VAR_BLUE:   prdata = DATA_W'(cfg_reg.var_blue);
            REG_PERIOD:     prdata = DATA_W'(cfg_reg.noise_period);
            REG_AMOUNT:     prdata = DATA_W'(cfg_reg.mottle_amount);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_red      <= RST_BASE_RED;
            cfg_reg.base_green    <= RST_BASE_GREEN;
            cfg_reg.base_blue     <= RST_BASE_BLUE;
            cfg_reg.var_red       <= RST_VAR;
            cfg_reg.var_green     <= RST_VAR;
            cfg_reg.var_blue      <= RST_VAR;
            cfg_reg.noise_period  <= RST_PERIOD;
            cfg_reg.mottle_amount <= RST_AMOUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

[rtl/tvn_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_front
// takes a pixel, counts the octaves that fit the tile and finds lattice cells
// ----------------------------------------------------------------------------
module tvn_front
    import tvn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PER_W-1:0]   noise_period,
    input  logic               q_full,
    output logic               q_push,
    output item_t              q_item
);

    localparam int XP_W = COORD_W + PER_W;
    localparam int PS_W = PER_W + MAX_OCTAVES;
    localparam int SX_W = XP_W + MAX_OCTAVES - 1;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                  input logic [PS_W-1:0]  p);
        logic [PS_W-1:0] s;
        s = PS_W'(i) + PS_W'(1);
        return (s == p) ? '0 : s[IDX_W-1:0];
    endfunction

    logic [PER_W-1:0]     per_eff;
    logic [XP_W-1:0]      xp;
    logic [XP_W-1:0]      yp;
    logic [MAX_OCTAVES-1:0] oct_ok;
    oct_coord_t           oct_next [MAX_OCTAVES];
    item_t                item_next;
    item_t                item_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 accept;

    // a zero period behaves as one; the tile is 256 wide so coordinates need no wrap
    assign per_eff = (noise_period == '0) ? PER_W'(1) : noise_period;
    assign xp      = XP_W'(x_coord) * XP_W'(per_eff);
    assign yp      = XP_W'(y_coord) * XP_W'(per_eff);

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_oct
        logic [PS_W-1:0] ps;
        logic [SX_W-1:0] sx;
        logic [SX_W-1:0] sy;

        assign ps        = PS_W'(per_eff) << o;
        assign sx        = SX_W'(xp) << o;
        assign sy        = SX_W'(yp) << o;
        assign oct_ok[o] = (ps <= PS_W'(TILE_SIZE));
        assign oct_next[o] = '{
            x0: sx[TILE_W +: IDX_W],
            x1: next_idx(sx[TILE_W +: IDX_W], ps),
            y0: sy[TILE_W +: IDX_W],
            y1: next_idx(sy[TILE_W +: IDX_W], ps),
            fx: sx[TILE_W-1:0],
            fy: sy[TILE_W-1:0]
        };
    end

    // octaves that fit always form a prefix, so a count is enough
    always_comb
    begin
        item_next.oct_cnt = '0;
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            item_next.oct[o]  = oct_next[o];
            item_next.oct_cnt = item_next.oct_cnt + OCT_CNT_W'(oct_ok[o]);
        end
    end

    assign q_push   = valid_reg && !q_full;
    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_item   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

[rtl/tvn_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_queue
// short item queue between front and back
// ----------------------------------------------------------------------------
module tvn_queue
    import tvn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

[rtl/tvn_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tvn_back
// noise pipeline: hash, smoothstep, blend, octave mix, colour and byte stage
// ----------------------------------------------------------------------------
module tvn_back
    import tvn_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            q_valid,
    input  item_t           q_item,
    output logic            q_pop,
    output logic [CH_W-1:0] red_out,
    output logic [CH_W-1:0] green_out,
    output logic [CH_W-1:0] blue_out,
    output logic            out_valid,
    input  logic            out_stall
);

    localparam int HASH_W  = 32;
    localparam int NUM_STG = 10;
    localparam int NUM_CH  = 3;
    localparam int NS_W    = FRAC_W + 2;
    localparam int U_W     = VAR_W + AMT_W + 1;
    localparam int PROD_W  = U_W + NS_W;
    localparam int CL_W    = PROD_W + 1;
    localparam int C_SHIFT = FRAC_W + COLOR_FRAC;
    localparam int C_FRAC  = C_SHIFT + COLOR_FRAC;
    localparam int CLAMP_W = C_FRAC + 1;
    localparam int RND_W   = CLAMP_W + CH_W;

    localparam logic [NS_W-1:0]   NS_ONE   = NS_W'(1) << FRAC_W;
    localparam logic [FRAC_W-1:0] HALF     = FRAC_W'(1) << (FRAC_W - 1);
    localparam logic [FRAC_W:0]   FRAC_ONE = (FRAC_W + 1)'(1) << FRAC_W;
    localparam logic signed [CL_W-1:0] C_ONE = CL_W'(1) << C_FRAC;

    function automatic logic [FRAC_W-1:0] sq_frac(input logic [FRAC_W-1:0] t);
        logic [2*FRAC_W-1:0] p;
        p = (2*FRAC_W)'(t) * (2*FRAC_W)'(t);
        return p[FRAC_W +: FRAC_W];
    endfunction

    function automatic logic [FRAC_W:0] smooth(input logic [FRAC_W-1:0] t2,
                                               input logic [FRAC_W-1:0] t);
        logic [FRAC_W+1:0]   k;
        logic [2*FRAC_W+1:0] p;
        k = ((FRAC_W + 2)'(3) << FRAC_W) - ((FRAC_W + 2)'(t) << 1);
        p = (2*FRAC_W + 2)'(t2) * (2*FRAC_W + 2)'(k);
        return p[FRAC_W +: FRAC_W + 1];
    endfunction

    function automatic logic [FRAC_W-1:0] blend(input logic [FRAC_W-1:0] a,
                                                input logic [FRAC_W-1:0] b,
                                                input logic [FRAC_W:0]   s);
        logic [2*FRAC_W+1:0] acc;
        acc = (2*FRAC_W + 2)'(a) * (2*FRAC_W + 2)'(FRAC_ONE - s)
            + (2*FRAC_W + 2)'(b) * (2*FRAC_W + 2)'(s);
        return acc[FRAC_W +: FRAC_W];
    endfunction

    function automatic logic [HASH_W-1:0] fold13(input logic [HASH_W-1:0] h);
        return h ^ (h >> 13);
    endfunction

    function automatic logic [FRAC_W-1:0] hash_frac(input logic [HASH_W-1:0] m);
        logic [HASH_W-1:0] f;
        f = m ^ (m >> 16);
        return f[FRAC_W-1:0];
    endfunction

    // floor(2^SUM_W / (2^n - 1)) from its repeating binary pattern
    function automatic logic [SUM_W-1:0] recip_of(input logic [OCT_CNT_W-1:0] n);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int j = 1; j <= SUM_W; j++)
        begin
            if (n != '0 && j * int'(n) <= SUM_W)
            begin
                r[SUM_W - j * int'(n)] = 1'b1;
            end
        end
        return r;
    endfunction

    logic                 en;
    logic [NUM_STG:1]     vld_reg;
    logic                 out_valid_reg;
    logic [OCT_CNT_W-1:0] cnt_pipe_reg [1:5];
    logic [FRAC_W-1:0]    oct_val [MAX_OCTAVES];

    assign en        = !out_valid_reg || !out_stall;
    assign q_pop     = en && q_valid;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NUM_STG-1:1], q_valid};
            out_valid_reg <= vld_reg[NUM_STG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_pipe_reg[1] <= q_item.oct_cnt;
            for (int k = 2; k <= 5; k++)
            begin
                cnt_pipe_reg[k] <= cnt_pipe_reg[k-1];
            end
        end
    end

    // one lane per octave, five stages from lattice cell to blended value
    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_oct
        oct_coord_t        c;
        logic [FRAC_W-1:0] tx;
        logic [FRAC_W-1:0] ty;
        logic [HASH_W-1:0] hx0_reg;
        logic [HASH_W-1:0] hx1_reg;
        logic [HASH_W-1:0] hy0_reg;
        logic [HASH_W-1:0] hy1_reg;
        logic [FRAC_W-1:0] tx_reg;
        logic [FRAC_W-1:0] ty_reg;
        logic [FRAC_W-1:0] tx2_reg;
        logic [FRAC_W-1:0] ty2_reg;
        logic [HASH_W-1:0] g_reg [4];
        logic [HASH_W-1:0] m_reg [4];
        logic [FRAC_W:0]   wx_reg;
        logic [FRAC_W:0]   wy_reg;
        logic [FRAC_W:0]   wx3_reg;
        logic [FRAC_W:0]   wy3_reg;
        logic [FRAC_W:0]   wy4_reg;
        logic [FRAC_W-1:0] top_reg;
        logic [FRAC_W-1:0] bot_reg;
        logic [FRAC_W-1:0] val_reg;

        assign c  = q_item.oct[o];
        assign tx = FRAC_W'(c.fx) << (FRAC_W - TILE_W);
        assign ty = FRAC_W'(c.fy) << (FRAC_W - TILE_W);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // first hash products and squared fractions
                hx0_reg <= HASH_W'(c.x0) * MIX_X;
                hx1_reg <= HASH_W'(c.x1) * MIX_X;
                hy0_reg <= HASH_W'(c.y0) * MIX_Y;
                hy1_reg <= HASH_W'(c.y1) * MIX_Y;
                tx_reg  <= tx;
                ty_reg  <= ty;
                tx2_reg <= sq_frac(tx);
                ty2_reg <= sq_frac(ty);
                // corner sums and smoothstep weights
                g_reg[0] <= fold13(hx0_reg + hy0_reg);
                g_reg[1] <= fold13(hx1_reg + hy0_reg);
                g_reg[2] <= fold13(hx0_reg + hy1_reg);
                g_reg[3] <= fold13(hx1_reg + hy1_reg);
                wx_reg   <= smooth(tx2_reg, tx_reg);
                wy_reg   <= smooth(ty2_reg, ty_reg);
                // final hash multiply
                for (int k = 0; k < 4; k++)
                begin
                    m_reg[k] <= g_reg[k] * MIX_F;
                end
                wx3_reg <= wx_reg;
                wy3_reg <= wy_reg;
                // blend along x, then along y
                top_reg <= blend(hash_frac(m_reg[0]), hash_frac(m_reg[1]), wx3_reg);
                bot_reg <= blend(hash_frac(m_reg[2]), hash_frac(m_reg[3]), wx3_reg);
                wy4_reg <= wy3_reg;
                val_reg <= blend(top_reg, bot_reg, wy4_reg);
            end
        end

        assign oct_val[o] = val_reg;
    end

    // weighted octave sum, divided by 2^(M-n) * (2^n - 1)
    logic [SUM_W-1:0]     oct_sum;
    logic [SUM_W-1:0]     norm_v;
    logic [SUM_W-1:0]     v6_reg;
    logic [OCT_CNT_W-1:0] cnt6_reg;
    logic [2*SUM_W-1:0]   rprod;
    logic [FRAC_W-1:0]    q0_reg;
    logic [SUM_W-1:0]     v7_reg;
    logic [OCT_CNT_W-1:0] cnt7_reg;
    logic [SUM_W-1:0]     qd;
    logic [SUM_W-1:0]     rem;
    logic [SUM_W-1:0]     dv;
    logic [FRAC_W-1:0]    quot;
    logic [FRAC_W-1:0]    noise;
    logic signed [NS_W-1:0] ns_next;
    logic signed [NS_W-1:0] ns_reg;

    always_comb
    begin
        oct_sum = '0;
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            if (OCT_CNT_W'(o) < cnt_pipe_reg[5])
            begin
                oct_sum = oct_sum + (SUM_W'(oct_val[o]) << (MAX_OCTAVES - 1 - o));
            end
        end
        norm_v = oct_sum >> (OCT_CNT_W'(MAX_OCTAVES) - cnt_pipe_reg[5]);
    end

    assign rprod = (2*SUM_W)'(v6_reg) * (2*SUM_W)'(recip_of(cnt6_reg));

    // reciprocal estimate is low by at most one
    always_comb
    begin
        qd      = (SUM_W'(q0_reg) << cnt7_reg) - SUM_W'(q0_reg);
        rem     = v7_reg - qd;
        dv      = (SUM_W'(1) << cnt7_reg) - SUM_W'(1);
        quot    = (rem >= dv) ? q0_reg + FRAC_W'(1) : q0_reg;
        noise   = (cnt7_reg == '0) ? HALF : quot;
        ns_next = $signed({1'b0, noise, 1'b0}) - $signed(NS_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v6_reg   <= norm_v;
            cnt6_reg <= cnt_pipe_reg[5];
            q0_reg   <= rprod[SUM_W +: FRAC_W];
            v7_reg   <= v6_reg;
            cnt7_reg <= cnt6_reg;
            ns_reg   <= ns_next;
        end
    end

    // colour channels
    logic [BASE_W-1:0] base_sel [NUM_CH];
    logic [VAR_W-1:0]  var_sel  [NUM_CH];
    logic [CH_W-1:0]   byte_val [NUM_CH];

    always_comb
    begin
        base_sel[0] = cfg.base_red;
        base_sel[1] = cfg.base_green;
        base_sel[2] = cfg.base_blue;
        var_sel[0]  = cfg.var_red;
        var_sel[1]  = cfg.var_green;
        var_sel[2]  = cfg.var_blue;
    end

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_ch
        logic signed [U_W-1:0]    var_s;
        logic signed [U_W-1:0]    amt_s;
        logic signed [U_W-1:0]    u_reg;
        logic signed [PROD_W-1:0] prod_next;
        logic signed [PROD_W-1:0] prod_reg;
        logic signed [CL_W-1:0]   base_s;
        logic signed [CL_W-1:0]   prod_s;
        logic signed [CL_W-1:0]   c_s;
        logic [CLAMP_W-1:0]       cl_next;
        logic [CLAMP_W-1:0]       cl_reg;
        logic [RND_W-1:0]         rnd;
        logic [CH_W-1:0]          byte_reg;

        assign var_s     = $signed(var_sel[ch]);
        assign amt_s     = $signed({1'b0, cfg.mottle_amount});
        assign prod_next = u_reg * ns_reg;

        always_comb
        begin
            base_s = $signed({{(CL_W - BASE_W - C_SHIFT){1'b0}}, base_sel[ch],
                              {C_SHIFT{1'b0}}});
            prod_s = prod_reg;
            c_s    = base_s + prod_s;
            if (c_s < 0)
            begin
                cl_next = '0;
            end
            else if (c_s > C_ONE)
            begin
                cl_next = C_ONE[CLAMP_W-1:0];
            end
            else
            begin
                cl_next = c_s[CLAMP_W-1:0];
            end
            // times 255 and round half up
            rnd = (RND_W'(cl_reg) << CH_W) - RND_W'(cl_reg) + (RND_W'(1) << (C_FRAC - 1));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                u_reg    <= var_s * amt_s;
                prod_reg <= prod_next;
                cl_reg   <= cl_next;
                byte_reg <= rnd[C_FRAC +: CH_W];
            end
        end

        assign byte_val[ch] = byte_reg;
    end

    assign red_out   = byte_val[0];
    assign green_out = byte_val[1];
    assign blue_out  = byte_val[2];

endmodule
`default_nettype wire
